FILE: rtl/core/gbn_sw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N sender window package
// Item types, event kinds, register indexes and reset values shared by the
// sender window core.
// ----------------------------------------------------------------------------
package gbn_sw_pkg;

    localparam int TOTAL_W = 24;

    // Event kinds carried by an input item.
    localparam logic [1:0] KIND_SEND  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [7:0] ACK_FLAG = 8'h02;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] CFG_TOTAL_BYTES   = 2'd2;

    localparam logic [5:0]         WINDOW_SIZE_RESET   = 6'd10;
    localparam logic [15:0]        TIMEOUT_TICKS_RESET = 16'd2000;
    localparam logic [TOTAL_W-1:0] TOTAL_BYTES_RESET   = '0;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] reply_flag;
        logic [7:0] reply_seq;
        logic       reply_checksum_ok;
    } t_gbn_in;

    typedef struct packed {
        logic        send_valid;
        logic [11:0] send_index;
        logic [7:0]  send_seq;
        logic [12:0] payload_length;
        logic        went_back;
        logic [5:0]  window_room;
        logic        transfer_done;
    } t_gbn_out;

endpackage
`default_nettype wire

FILE: rtl/core/go_back_n_sender_window_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N sender window core
// Tracks the send window of a Go-Back-N transfer and issues one result item
// for every event item: send slot, reply received or timer tick.
// ----------------------------------------------------------------------------
// Usage:
// Event items enter on i_in_valid / o_in_stall and are taken at an edge where
// i_in_valid is high and o_in_stall is low. Each item yields exactly one result
// item on o_out_valid / i_out_stall. An item is captured in the input register
// at its accepting edge and evaluated against the window state from there; its
// result is then registered in the output register. The state update is a
// single pass of adds and compares, so a new item is taken every cycle (one
// item per cycle sustained) while the receiver does not stall. When the
// receiver stalls, the result stays in the output register, an item waiting
// in the input register stays there and o_in_stall rises.
// Configuration writes (window size, timeout, total bytes) go through the
// i_cfg_valid / o_cfg_ready port, which is always ready; they are meant to be
// done while no item is in flight. Reset restores the register defaults, marks
// nothing acknowledged and empties both pipeline registers.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core
    import gbn_sw_pkg::*;
#(
    parameter int MAX_PAYLOAD = 4096,
    parameter int SEQ_SPACE   = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Event items
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire t_gbn_in            i_in_data,
    // Result items
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      t_gbn_out           o_out_data,
    // Configuration writes
    input  wire logic               i_cfg_valid,
    output      logic               o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [TOTAL_W-1:0] i_cfg_data
);

    // Largest packet count a 24-bit transfer can need, and the index width that
    // holds every value from zero up to it.
    localparam int PKT_MAX = ((2 ** TOTAL_W) - 1 + MAX_PAYLOAD - 1) / MAX_PAYLOAD;
    localparam int IDX_W   = $clog2(PKT_MAX + 1);
    // Byte offsets: a packet start plus up to 255 packets of payload.
    localparam int OFF_W   = TOTAL_W + 2;

    localparam logic [OFF_W-1:0] MP_OFF = OFF_W'(MAX_PAYLOAD);
    localparam logic [8:0]       SEQ_S  = 9'(SEQ_SPACE);

    // Configuration registers.
    logic [5:0]         r_window;
    logic [15:0]        r_timeout;
    logic [TOTAL_W-1:0] r_total;

    // Window state. The base is the first unacknowledged packet, that is the
    // last acknowledged index plus one. Each index is shadowed by its byte
    // offset and its sequence number so no division is needed per item.
    logic [IDX_W-1:0] r_base,      n_base;
    logic [OFF_W-1:0] r_base_off,  n_base_off;
    logic [7:0]       r_base_seq,  n_base_seq;
    logic [IDX_W-1:0] r_next,      n_next;
    logic [OFF_W-1:0] r_next_off,  n_next_off;
    logic [7:0]       r_next_seq,  n_next_seq;
    logic [15:0]      r_ticks,     n_ticks;

    // Pipeline registers.
    logic     r_in_valid;
    t_gbn_in  r_in;
    logic     r_out_valid;
    t_gbn_out r_out;
    t_gbn_out n_out;

    logic w_go;

    // Combinational terms.
    logic [OFF_W-1:0] w_total;
    logic             w_done_now;
    logic [IDX_W-1:0] w_inflight;
    logic             w_has_room;
    logic             w_can_send;
    logic             w_is_tail;
    logic [OFF_W-1:0] w_tail_len;
    logic [7:0]       w_bpos;
    logic [8:0]       w_dsum;
    logic [7:0]       w_delta;
    logic [7:0]       w_delta_m1;
    logic [OFF_W-1:0] w_adv_off;
    logic [OFF_W-1:0] w_last_off;
    logic [8:0]       w_seq_sum;
    logic             w_good_reply;
    logic             w_ack_ok;
    logic [15:0]      w_tick_inc;
    logic [IDX_W-1:0] w_infl_after;

    assign o_cfg_ready = 1'b1;
    assign w_go        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_total    = OFF_W'(r_total);
        w_done_now = (r_base_off >= w_total);
        w_inflight = r_next - r_base;
        w_has_room = (w_inflight < IDX_W'(r_window));
        w_can_send = (r_next_off < w_total) && w_has_room;
        w_is_tail  = ((r_next_off + MP_OFF) >= w_total);
        w_tail_len = w_total - r_next_off;

        // Sequence position of the last acknowledged packet, and the unwrapped
        // distance from it to the sequence number in the reply.
        w_bpos     = (r_base_seq == 8'd0) ? 8'(SEQ_S - 9'd1) : (r_base_seq - 8'd1);
        w_dsum     = {1'b0, r_in.reply_seq} + SEQ_S - {1'b0, w_bpos};
        if (w_dsum >= SEQ_S) begin
            w_dsum = w_dsum - SEQ_S;
        end
        w_delta    = w_dsum[7:0];
        w_delta_m1 = w_delta - 8'd1;
        w_last_off = r_base_off + (OFF_W'(w_delta_m1) * MP_OFF);
        w_adv_off  = w_last_off + MP_OFF;
        w_seq_sum  = {1'b0, r_base_seq} + {1'b0, w_delta};
        if (w_seq_sum >= SEQ_S) begin
            w_seq_sum = w_seq_sum - SEQ_S;
        end

        w_good_reply = r_in.reply_checksum_ok && (r_in.reply_flag == ACK_FLAG);
        w_ack_ok     = ({1'b0, r_in.reply_seq} < SEQ_S)
                    && (w_delta != 8'd0)
                    && (w_delta <= {2'b00, r_window})
                    && (w_last_off < w_total);
        w_tick_inc   = (r_ticks == 16'hFFFF) ? r_ticks : (r_ticks + 16'd1);

        n_base     = r_base;
        n_base_off = r_base_off;
        n_base_seq = r_base_seq;
        n_next     = r_next;
        n_next_off = r_next_off;
        n_next_seq = r_next_seq;
        n_ticks    = r_ticks;
        n_out      = '0;

        if (!w_done_now) begin
            case (r_in.kind)
                KIND_SEND: begin
                    if (w_can_send) begin
                        n_out.send_valid     = 1'b1;
                        n_out.send_index     = 12'({{12{1'b0}}, r_next});
                        n_out.send_seq       = r_next_seq;
                        n_out.payload_length = w_is_tail ? w_tail_len[12:0] : MP_OFF[12:0];
                        n_ticks              = '0;
                        n_next               = r_next + IDX_W'(1);
                        n_next_off           = r_next_off + MP_OFF;
                        n_next_seq           = (9'({1'b0, r_next_seq}) + 9'd1 >= SEQ_S)
                                             ? 8'd0 : (r_next_seq + 8'd1);
                    end
                end
                KIND_REPLY: begin
                    if (!w_good_reply) begin
                        n_next          = r_base;
                        n_next_off      = r_base_off;
                        n_next_seq      = r_base_seq;
                        n_out.went_back = 1'b1;
                    end else if (w_ack_ok) begin
                        n_base     = r_base + IDX_W'(w_delta);
                        n_base_off = w_adv_off;
                        n_base_seq = w_seq_sum[7:0];
                        // An ack past the next packet pulls the next packet up.
                        if (r_next < n_base) begin
                            n_next     = n_base;
                            n_next_off = n_base_off;
                            n_next_seq = n_base_seq;
                        end
                    end
                end
                KIND_TICK: begin
                    n_ticks = w_tick_inc;
                    if (w_tick_inc > r_timeout) begin
                        n_next          = r_base;
                        n_next_off      = r_base_off;
                        n_next_seq      = r_base_seq;
                        n_out.went_back = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        w_infl_after        = n_next - n_base;
        n_out.window_room   = (w_infl_after >= IDX_W'(r_window))
                            ? 6'd0 : (r_window - w_infl_after[5:0]);
        n_out.transfer_done = (n_base_off >= w_total);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_SIZE_RESET;
            r_timeout <= TIMEOUT_TICKS_RESET;
            r_total   <= TOTAL_BYTES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW_SIZE:   r_window  <= i_cfg_data[5:0];
                CFG_TIMEOUT_TICKS: r_timeout <= i_cfg_data[15:0];
                CFG_TOTAL_BYTES:   r_total   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Window state advances only when an item passes through the logic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_base_off <= '0;
            r_base_seq <= '0;
            r_next     <= '0;
            r_next_off <= '0;
            r_next_seq <= '0;
            r_ticks    <= '0;
        end else if (w_go) begin
            r_base     <= n_base;
            r_base_off <= n_base_off;
            r_base_seq <= n_base_seq;
            r_next     <= n_next;
            r_next_off <= n_next_off;
            r_next_seq <= n_next_seq;
            r_ticks    <= n_ticks;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out <= n_out;
        end
    end

    // The next packet never falls behind the window base.
    a_next_not_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next >= r_base) && (r_next_off >= r_base_off))
        else $error("next packet is behind the window base");

    // A send neither rewinds nor completes the transfer.
    a_send_not_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.send_valid) |->
        (!o_out_data.went_back && !o_out_data.transfer_done))
        else $error("send result also reports rewind or completion");

    // A held result freezes the window state.
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        ($stable(r_next) && $stable(r_base) && $stable(r_ticks)))
        else $error("window state moved while the result was held");

    // A send leaves the timer cleared.
    a_send_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && n_out.send_valid) |=> (r_ticks == 16'd0))
        else $error("timer not restarted by a send");

endmodule
`default_nettype wire
